@@ rtl/upd_pkg.sv @@
package upd_pkg;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [4:0] HEX_BAD    = 5'd16;
  localparam int unsigned MAX_OUT   = 3;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PCT,
    PH_HOLD
  } phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]                 cnt;
    out_item_t [MAX_OUT-1:0]    item;
  } bundle_t;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = HEX_BAD;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h61 + 8'd10);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h41 + 8'd10);
    return v;
  endfunction

  function automatic logic [7:0] plain_map(input logic [7:0] c);
    return (c == CH_PLUS) ? CH_SPACE : c;
  endfunction

endpackage

@@ rtl/upd_in_if.sv @@
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

@@ rtl/upd_out_if.sv @@
interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

@@ rtl/upd_front.sv @@
module upd_front import upd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  upd_in_if.sink    in_i,
  input  logic      full_i,
  output logic      push_o,
  output bundle_t   bundle_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] first_q, first_d;
  logic       fire;
  logic [4:0] hi, lo;
  logic       esc_ok;
  logic [1:0] n;
  out_item_t [MAX_OUT-1:0] it;

  assign in_i.ready = !full_i;
  assign fire       = in_i.valid && !full_i;

  assign hi     = hex_val(first_q);
  assign lo     = hex_val(in_i.in_byte);
  assign esc_ok = !hi[4] && !lo[4] && ({hi[3:0], lo[3:0]} != 8'h00);

  always_comb begin
    phase_d = PH_IDLE;
    first_d = first_q;
    n       = 2'd0;
    it      = '0;
    case (phase_q)
      PH_PCT: begin
        if (in_i.in_last) begin
          it[n] = '{data: CH_PERCENT, last: 1'b0};
          n     = n + 2'd1;
          it[n] = '{data: plain_map(in_i.in_byte), last: 1'b1};
          n     = n + 2'd1;
        end else begin
          phase_d = PH_HOLD;
          first_d = in_i.in_byte;
        end
      end
      PH_HOLD: begin
        if (esc_ok) begin
          it[n] = '{data: {hi[3:0], lo[3:0]}, last: in_i.in_last};
          n     = n + 2'd1;
        end else begin
          it[n] = '{data: CH_PERCENT, last: 1'b0};
          n     = n + 2'd1;
          if (first_q == CH_PERCENT) begin
            // held percent opens a new escape on the current byte unless it is the last
            if (in_i.in_last) begin
              it[n] = '{data: CH_PERCENT, last: 1'b0};
              n     = n + 2'd1;
              it[n] = '{data: plain_map(in_i.in_byte), last: 1'b1};
              n     = n + 2'd1;
            end else begin
              phase_d = PH_HOLD;
              first_d = in_i.in_byte;
            end
          end else begin
            it[n] = '{data: plain_map(first_q), last: 1'b0};
            n     = n + 2'd1;
            if (in_i.in_byte == CH_PERCENT && !in_i.in_last) begin
              phase_d = PH_PCT;
            end else begin
              it[n] = '{data: plain_map(in_i.in_byte), last: in_i.in_last};
              n     = n + 2'd1;
            end
          end
        end
      end
      default: begin
        if (in_i.in_byte == CH_PERCENT && !in_i.in_last) begin
          phase_d = PH_PCT;
        end else begin
          it[n] = '{data: plain_map(in_i.in_byte), last: in_i.in_last};
          n     = n + 2'd1;
        end
      end
    endcase
  end

  assign push_o        = fire && (n != 2'd0);
  assign bundle_o.cnt  = n;
  assign bundle_o.item = it;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      first_q <= 8'h00;
    end else if (fire) begin
      phase_q <= phase_d;
      first_q <= first_d;
    end
  end

`ifndef SYNTHESIS
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_i.in_last) |=> (phase_q == PH_IDLE))
    else $error("phase not idle after last transaction");
  a_last_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_i.in_last) |-> (push_o && bundle_o.item[bundle_o.cnt - 2'd1].last))
    else $error("last transaction without final output");
`endif

endmodule

@@ rtl/upd_fifo.sv @@
module upd_fifo import upd_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t push_data_i,
  output logic    full_o,
  input  logic    pop_i,
  output bundle_t pop_data_o,
  output logic    empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  bundle_t         mem_q [DEPTH];
  logic [PW-1:0]   wptr_q, rptr_q;
  logic [CW-1:0]   count_q;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o     = (count_q == CW'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= ptr_inc(wptr_q);
      if (pop_i)  rptr_q <= ptr_inc(rptr_q);
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");
`endif

endmodule

@@ rtl/upd_back.sv @@
module upd_back import upd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  bundle_t   bundle_i,
  output logic      pop_o,
  upd_out_if.source out_o
);

  bundle_t    cur_q;
  logic [1:0] idx_q;
  logic       busy_q;
  logic       done;
  out_item_t  sel;

  assign sel          = cur_q.item[idx_q];
  assign out_o.valid    = busy_q;
  assign out_o.out_byte = sel.data;
  assign out_o.out_last = sel.last;

  assign done  = busy_q && out_o.ready && (idx_q == cur_q.cnt - 2'd1);
  assign pop_o = !empty_i && (!busy_q || done);

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= bundle_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= 2'd0;
    end else if (done) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else if (busy_q && out_o.ready) begin
      idx_q  <= idx_q + 2'd1;
    end
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q < cur_q.cnt))
    else $error("output index beyond bundle");
  a_last_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && sel.last) |-> (idx_q == cur_q.cnt - 2'd1))
    else $error("last flag before end of bundle");
`endif

endmodule

@@ rtl/url_percent_decoder.sv @@
// Streaming URL percent-decoder. One encoded byte per input transaction, one decoded
// byte per output transaction; '+' becomes a space and '%' with two hex digits becomes
// that byte, while a bad or zero escape yields '%' followed by the held bytes decoded
// again. A byte is accepted every cycle while the queue between the classifier and the
// output serializer has room; each input byte gives zero to three outputs, and the
// serializer emits one output per cycle while the receiver is ready, so input can be
// sustained at one byte per cycle except that the extra outputs of an error escape can
// fill the queue and hold off input. Outputs pass through the queue and a bundle register.
module url_percent_decoder import upd_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  upd_in_if.sink    in_i,
  upd_out_if.source out_o
);

  logic    push, pop, full, empty;
  bundle_t push_data, pop_data;

  upd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .full_i   (full),
    .push_o   (push),
    .bundle_o (push_data)
  );

  upd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  upd_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .bundle_i (pop_data),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule

@@ tb/sv/url_percent_decoder_tb.sv @@
`timescale 1ns / 1ps

module url_percent_decoder_tb;
  import upd_pkg::*;

  localparam int unsigned N_RANDOM     = 500;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned LONG_STALL   = 300;
  localparam int unsigned STALL_AFTER  = 120;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic [7:0] b;
    logic       l;
  } enc_item_t;

  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_CADENCE
  } rx_mode_e;

  // Tracks escape state and holds decoded bytes still owed by the block.
  class decode_scoreboard;
    phase_e     phase;
    logic [7:0] held;
    out_item_t  expected_q[$];
    int         mismatches;

    function new();
      phase      = PH_IDLE;
      held       = '0;
      mismatches = 0;
    endfunction

    function int nibble(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      return -1;
    endfunction

    function void emit(logic [7:0] d, logic l);
      out_item_t it;
      it.data = d;
      it.last = l;
      expected_q.insert(expected_q.size(), it);
    endfunction

    function void plain(logic [7:0] b, logic l);
      phase = PH_IDLE;
      if (b == CH_PLUS) begin
        emit(CH_SPACE, l);
      end else if (b == CH_PERCENT) begin
        if (l) emit(CH_PERCENT, 1'b1);
        else phase = PH_PCT;
      end else begin
        emit(b, l);
      end
    endfunction

    function void after_percent(logic [7:0] b, logic l);
      if (l) begin
        phase = PH_IDLE;
        emit(CH_PERCENT, 1'b0);
        plain(b, 1'b1);
      end else begin
        held  = b;
        phase = PH_HOLD;
      end
    endfunction

    function void note_input(logic [7:0] b, logic l);
      int         hi;
      int         lo;
      logic [7:0] h;
      case (phase)
        PH_PCT: after_percent(b, l);
        PH_HOLD: begin
          h     = held;
          hi    = nibble(h);
          lo    = nibble(b);
          phase = PH_IDLE;
          if (hi >= 0 && lo >= 0 && (hi * 16 + lo) != 0) begin
            emit(8'(hi * 16 + lo), l);
          end else begin
            // bad escape: literal percent, then both held bytes again
            emit(CH_PERCENT, 1'b0);
            plain(h, 1'b0);
            if (phase == PH_PCT) after_percent(b, l);
            else plain(b, l);
          end
        end
        default: plain(b, l);
      endcase
    endfunction

    function void fail(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function void check_output(logic [7:0] d, logic l);
      out_item_t want;
      if (expected_q.size() == 0) begin
        fail($sformatf("unexpected output transaction: data %02h last %0b", d, l));
        return;
      end
      want = expected_q.pop_front();
      if (want.data !== d || want.last !== l) begin
        fail($sformatf("output mismatch: expected data %02h last %0b, got data %02h last %0b",
                       want.data, want.last, d, l));
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  upd_in_if  in_if ();
  upd_out_if out_if ();

  url_percent_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  decode_scoreboard sb;
  enc_item_t        stim_q[$];
  int unsigned      cycles       = 0;
  int unsigned      inputs_taken = 0;
  bit               stall_done   = 1'b0;

  function automatic logic [7:0] hex_char(logic [3:0] n, logic up);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (up ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic void add_byte(logic [7:0] b, logic l);
    enc_item_t it;
    it.b = b;
    it.l = l;
    stim_q.insert(stim_q.size(), it);
  endfunction

  function automatic void add_text(string s, logic end_last);
    for (int i = 0; i < s.len(); i++) begin
      add_byte(s[i], (i == s.len() - 1) ? end_last : 1'b0);
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // transaction monitor on both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) sb.check_output(out_if.out_byte, out_if.out_last);
      if (in_if.valid && in_if.ready) begin
        sb.note_input(in_if.in_byte, in_if.in_last);
        inputs_taken++;
      end
    end
  end

  // receiver: changing stall patterns plus one long hold-off
  initial begin
    rx_mode_e    mode;
    int unsigned span;
    int unsigned k;
    out_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    k = 0;
    forever begin
      if (!stall_done && inputs_taken >= STALL_AFTER) begin
        stall_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk_i);
      end
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(8, 60);
      repeat (span) begin
        case (mode)
          RX_ALWAYS:  out_if.ready <= 1'b1;
          RX_COIN:    out_if.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE:  out_if.ready <= ($urandom_range(0, 3) == 0);
          default:    out_if.ready <= (k % 4 != 3);
        endcase
        k++;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned idx;
    int unsigned burst;
    int unsigned gap;
    int unsigned n_rand;
    int unsigned base;
    int unsigned kind;
    logic [7:0]  val;
    enc_item_t   tail;

    sb = new();
    in_if.valid   <= 1'b0;
    in_if.in_byte <= '0;
    in_if.in_last <= 1'b0;

    // directed: byte extremes, plus, both digit cases, zero and non-hex escapes,
    // a percent as first digit, and escapes cut short by the end of the string
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(CH_PLUS, 1'b1);
    add_text("%fF", 1'b1);
    add_text("%00", 1'b1);
    add_text("%g1", 1'b1);
    add_text("%9/", 1'b1);
    add_text("%%41", 1'b1);
    add_text("%", 1'b1);
    add_text("%4", 1'b1);
    add_text("%%x", 1'b1);

    // random strings of plain bytes, plus signs and escapes, some escapes zero or broken
    n_rand = 0;
    while (n_rand < N_RANDOM) begin
      base = stim_q.size();
      repeat ($urandom_range(1, 6)) begin
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
          add_byte(8'($urandom_range(0, 255)), 1'b0);
        end else if (kind < 50) begin
          add_byte(CH_PLUS, 1'b0);
        end else if (kind < 78) begin
          val = 8'($urandom_range(1, 255));
          add_byte(CH_PERCENT, 1'b0);
          add_byte(hex_char(val[7:4], 1'($urandom_range(0, 1))), 1'b0);
          add_byte(hex_char(val[3:0], 1'($urandom_range(0, 1))), 1'b0);
        end else if (kind < 83) begin
          add_text("%00", 1'b0);
        end else begin
          add_byte(CH_PERCENT, 1'b0);
          repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 3))
              0: val = hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
              1: val = CH_PERCENT;
              2: val = 8'($urandom_range(0, 255));
              default: val = 8'h30;
            endcase
            add_byte(val, 1'b0);
          end
        end
      end
      tail = stim_q.pop_back();
      tail.l = 1'b1;
      stim_q.insert(stim_q.size(), tail);
      n_rand += stim_q.size() - base;
    end

    wait (rst_ni);
    @(posedge clk_i);

    idx = 0;
    while (idx < stim_q.size()) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && idx < stim_q.size()) begin
        in_if.valid   <= 1'b1;
        in_if.in_byte <= stim_q[idx].b;
        in_if.in_last <= stim_q[idx].l;
        do @(posedge clk_i); while (!in_if.ready);
        idx++;
        burst--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_if.valid <= 1'b0;
    @(posedge clk_i);

    while (sb.pending() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/upd_pkg.sv
rtl/upd_in_if.sv
rtl/upd_out_if.sv
rtl/upd_front.sv
rtl/upd_fifo.sv
rtl/upd_back.sv
rtl/url_percent_decoder.sv
tb/sv/url_percent_decoder_tb.sv
